FILE: hw/rtl/lss_pkg.sv
// Shared types and constants for the line shape sum evaluator.
package lss_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned SumWidth   = 40;

  localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
  localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};

  typedef enum logic [0:0] {
    MODEL_LORENTZ = 1'b0,
    MODEL_FANO    = 1'b1
  } line_model_e;

  typedef struct packed {
    logic [32:0] dist_mag;
    logic        dist_neg;
    logic [30:0] width;
    logic [15:0] asym;
    logic [31:0] amp_mag;
    logic        amp_neg;
    logic        zero_width;
    logic        last_term;
  } term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_DSQ,
    ST_GSQ,
    ST_QD,
    ST_QQ,
    ST_VSQ,
    ST_WDEN,
    ST_SCALE,
    ST_DIV,
    ST_AMUL,
    ST_ACC,
    ST_EMIT
  } back_state_e;

endpackage

FILE: hw/rtl/lss_front.sv
// Input stage: accepts a term request, forms |x - x0| and |a| and flags a zero width.
module lss_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  x_value_i,
  input  logic signed [31:0]  amplitude_i,
  input  logic signed [31:0]  location_i,
  input  logic        [30:0]  width_i,
  input  logic signed [15:0]  asymmetry_i,
  input  logic                last_term_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output lss_pkg::term_t      q_data_o
);

  logic           valid_q, valid_d;
  lss_pkg::term_t item_q, item_d;
  logic signed [32:0] diff;
  logic        [32:0] amp_ext;
  logic               accept;

  assign q_push_o   = valid_q && !q_full_i;
  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_data_o   = item_q;

  always_comb begin
    diff    = {x_value_i[31], x_value_i} - {location_i[31], location_i};
    amp_ext = {amplitude_i[31], amplitude_i};
    item_d.dist_neg   = diff[32];
    item_d.dist_mag   = diff[32] ? 33'(-diff) : 33'(diff);
    item_d.width      = width_i;
    item_d.asym       = asymmetry_i;
    item_d.amp_neg    = amplitude_i[31];
    item_d.amp_mag    = amplitude_i[31] ? 32'(-amp_ext) : amplitude_i;
    item_d.zero_width = (width_i == '0);
    item_d.last_term  = last_term_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (q_push_o) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

FILE: hw/rtl/lss_fifo.sv
// Short request queue between the input stage and the evaluation engine.
module lss_fifo #(
  parameter int unsigned Depth = lss_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lss_pkg::term_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lss_pkg::term_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lss_pkg::term_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/lss_back.sv
// Evaluation engine: shape ratio on a shared multiplier and a divider, accumulation, result register.
module lss_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  lss_pkg::term_t      q_data_i,
  output logic                q_pop_o,
  input  logic                line_model_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [39:0]  spectrum_value_o,
  output logic                error_flag_o
);

  lss_pkg::back_state_e state_q, state_d;
  lss_pkg::term_t       item_q, item_d;

  logic [32:0] nm_q, nm_d, ng_q, ng_d, norm_max;
  logic [30:0] sumsq_q, sumsq_d;
  logic [30:0] av_q, av_d;
  logic [30:0] w_q, w_d;
  logic [63:0] num_q, num_d, den_q, den_d;
  logic [31:0] rem_q, rem_d;
  logic [30:0] lo_q, lo_d;
  logic [30:0] quot_q, quot_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [32:0] mag_q, mag_d;
  logic signed [39:0] acc_q, acc_d;
  logic        err_q, err_d;
  logic        outv_q, outv_d, oute_q, oute_d;
  logic signed [39:0] outs_q, outs_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [15:0] q_mag;
  logic        fano, norm_done, out_free;
  logic signed [32:0] prod_s, v_s;
  logic [32:0] rem2;
  logic        ge;
  logic [63:0] rnd;
  logic signed [40:0] term_s, sum_s;

  assign fano      = (line_model_i == lss_pkg::MODEL_FANO);
  assign q_mag     = item_q.asym[15] ? 16'(-item_q.asym) : item_q.asym;
  assign norm_max  = (nm_q > ng_q) ? nm_q : ng_q;
  assign norm_done = (norm_max[32:15] == '0) && norm_max[14];
  assign out_free  = !outv_q || !out_stall_i;

  assign out_valid_o      = outv_q;
  assign spectrum_value_o = outs_q;
  assign error_flag_o     = oute_q;

  // One multiplier shared by all product steps.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      lss_pkg::ST_DSQ: begin
        mul_a = {17'b0, nm_q[14:0]};
        mul_b = {17'b0, nm_q[14:0]};
      end
      lss_pkg::ST_GSQ: begin
        mul_a = {17'b0, ng_q[14:0]};
        mul_b = {17'b0, ng_q[14:0]};
      end
      lss_pkg::ST_QD: begin
        mul_a = {16'b0, q_mag};
        mul_b = {17'b0, nm_q[14:0]};
      end
      lss_pkg::ST_QQ: begin
        mul_a = {16'b0, q_mag};
        mul_b = {16'b0, q_mag};
      end
      lss_pkg::ST_VSQ: begin
        mul_a = {1'b0, av_q};
        mul_b = {1'b0, av_q};
      end
      lss_pkg::ST_WDEN: begin
        mul_a = {1'b0, w_q};
        mul_b = {1'b0, sumsq_q};
      end
      lss_pkg::ST_AMUL: begin
        mul_a = item_q.amp_mag;
        mul_b = {1'b0, quot_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lss_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          state_d = q_data_i.zero_width ? lss_pkg::ST_ACC : lss_pkg::ST_NORM;
        end
      end
      lss_pkg::ST_NORM: begin
        if (norm_done) begin
          state_d = lss_pkg::ST_DSQ;
        end
      end
      lss_pkg::ST_DSQ:  state_d = lss_pkg::ST_GSQ;
      lss_pkg::ST_GSQ:  state_d = fano ? lss_pkg::ST_QD : lss_pkg::ST_SCALE;
      lss_pkg::ST_QD:   state_d = lss_pkg::ST_QQ;
      lss_pkg::ST_QQ:   state_d = lss_pkg::ST_VSQ;
      lss_pkg::ST_VSQ:  state_d = lss_pkg::ST_WDEN;
      lss_pkg::ST_WDEN: state_d = lss_pkg::ST_SCALE;
      lss_pkg::ST_SCALE: begin
        if (den_q[63:32] == '0) begin
          state_d = lss_pkg::ST_DIV;
        end
      end
      lss_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = lss_pkg::ST_AMUL;
        end
      end
      lss_pkg::ST_AMUL: state_d = lss_pkg::ST_ACC;
      lss_pkg::ST_ACC:  state_d = item_q.last_term ? lss_pkg::ST_EMIT : lss_pkg::ST_IDLE;
      lss_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = lss_pkg::ST_IDLE;
        end
      end
      default: state_d = lss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = (state_q == lss_pkg::ST_IDLE) && !q_empty_i;
  end

  always_comb begin
    item_d  = item_q;
    nm_d    = nm_q;
    ng_d    = ng_q;
    sumsq_d = sumsq_q;
    av_d    = av_q;
    w_d     = w_q;
    num_d   = num_q;
    den_d   = den_q;
    rem_d   = rem_q;
    lo_d    = lo_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    acc_d   = acc_q;
    err_d   = err_q;
    outv_d  = outv_q && out_stall_i;
    outs_d  = outs_q;
    oute_d  = oute_q;
    prod_s  = {2'b0, mul_p[30:0]};
    v_s     = '0;
    rem2    = {rem_q, lo_q[30]};
    ge      = (rem2 >= {1'b0, den_q[31:0]});
    rnd     = mul_p + 64'(1 << 29);
    term_s  = item_q.amp_neg ? -$signed({8'b0, mag_q}) : $signed({8'b0, mag_q});
    sum_s   = {acc_q[39], acc_q} + term_s;
    case (state_q)
      lss_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          item_d = q_data_i;
          nm_d   = q_data_i.dist_mag;
          ng_d   = {2'b0, q_data_i.width};
        end
      end
      // Scale |d| and g together until the larger one has 15 significant bits.
      lss_pkg::ST_NORM: begin
        if (norm_max[32:15] != '0) begin
          nm_d = nm_q >> 1;
          ng_d = ng_q >> 1;
        end else if (!norm_max[14]) begin
          nm_d = nm_q << 1;
          ng_d = ng_q << 1;
        end
      end
      lss_pkg::ST_DSQ: begin
        sumsq_d = mul_p[30:0];
      end
      lss_pkg::ST_GSQ: begin
        sumsq_d = sumsq_q + mul_p[30:0];
        num_d   = {34'b0, mul_p[29:0]};
        den_d   = {33'b0, 31'(sumsq_q + mul_p[30:0])};
      end
      lss_pkg::ST_QD: begin
        v_s  = ((item_q.asym[15] ^ item_q.dist_neg) ? -prod_s : prod_s)
               + $signed({10'b0, ng_q[14:0], 8'b0});
        av_d = v_s[32] ? 31'(-v_s) : v_s[30:0];
      end
      lss_pkg::ST_QQ: begin
        w_d = 31'(65536) + mul_p[30:0];
      end
      lss_pkg::ST_VSQ: begin
        num_d = mul_p;
      end
      lss_pkg::ST_WDEN: begin
        den_d = mul_p;
      end
      lss_pkg::ST_SCALE: begin
        if (den_q[63:32] != '0) begin
          den_d = den_q >> 1;
          num_d = num_q >> 1;
        end else begin
          rem_d  = {1'b0, num_q[31:1]};
          lo_d   = {num_q[0], 30'b0};
          quot_d = '0;
          cnt_d  = 5'd30;
        end
      end
      // Restoring division, one quotient bit per cycle.
      lss_pkg::ST_DIV: begin
        rem_d  = ge ? 32'(rem2 - {1'b0, den_q[31:0]}) : rem2[31:0];
        lo_d   = lo_q << 1;
        quot_d = {quot_q[29:0], ge};
        cnt_d  = cnt_q - 1'b1;
      end
      lss_pkg::ST_AMUL: begin
        mag_d = rnd[62:30];
      end
      lss_pkg::ST_ACC: begin
        if (item_q.zero_width) begin
          acc_d = item_q.amp_neg ? lss_pkg::SumMin : lss_pkg::SumMax;
          err_d = 1'b1;
        end else if (!sum_s[40] && sum_s[39]) begin
          acc_d = lss_pkg::SumMax;
          err_d = 1'b1;
        end else if (sum_s[40] && !sum_s[39]) begin
          acc_d = lss_pkg::SumMin;
          err_d = 1'b1;
        end else begin
          acc_d = sum_s[39:0];
        end
      end
      lss_pkg::ST_EMIT: begin
        if (out_free) begin
          outv_d = 1'b1;
          outs_d = acc_q;
          oute_d = err_q;
          acc_d  = '0;
          err_d  = 1'b0;
        end
      end
      default: begin
        item_d = item_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lss_pkg::ST_IDLE;
      acc_q   <= '0;
      err_q   <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      err_q   <= err_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    nm_q    <= nm_d;
    ng_q    <= ng_d;
    sumsq_q <= sumsq_d;
    av_q    <= av_d;
    w_q     <= w_d;
    num_q   <= num_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    lo_q    <= lo_d;
    quot_q  <= quot_d;
    cnt_q   <= cnt_d;
    mag_q   <= mag_d;
    outs_q  <= outs_d;
    oute_q  <= oute_d;
  end

endmodule

FILE: hw/rtl/line_shape_sum_evaluator_core.sv
// Top level of the line shape sum evaluator: input stage, request queue, evaluation engine.
// A term's time in the engine depends on the model, the normalize shifter, the denominator scaling
// shifter and the 31-step divider; a zero-width term skips them and goes straight to accumulation.
// The input stage and two-entry queue take further requests while the engine works.
// After the last term, the sum passes through the accumulator and then the result register.
// Reset clears the running sum, the sticky error, the model register (Lorentzian) and all valids.
module line_shape_sum_evaluator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  x_value_i,
  input  logic signed [31:0]  amplitude_i,
  input  logic signed [31:0]  location_i,
  input  logic        [30:0]  width_i,
  input  logic signed [15:0]  asymmetry_i,
  input  logic                last_term_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [39:0]  spectrum_value_o,
  output logic                error_flag_o
);

  logic           model_q, model_d;
  logic           q_push, q_full, q_pop, q_empty;
  lss_pkg::term_t q_in, q_out;

  assign model_d = cfg_we_i ? cfg_wdata_i : model_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= lss_pkg::MODEL_LORENTZ;
    end else begin
      model_q <= model_d;
    end
  end

  lss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_value_i   (x_value_i),
    .amplitude_i (amplitude_i),
    .location_i  (location_i),
    .width_i     (width_i),
    .asymmetry_i (asymmetry_i),
    .last_term_i (last_term_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_in)
  );

  lss_fifo #(
    .Depth (lss_pkg::QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  lss_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_data_i         (q_out),
    .q_pop_o          (q_pop),
    .line_model_i     (model_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .spectrum_value_o (spectrum_value_o),
    .error_flag_o     (error_flag_o)
  );

endmodule
